>>> hw/rtl/npm_pkg.sv
// npm_pkg: shared constants and types of the nearest point height mapper
// used by the top level, npm_front and npm_scan under hw/rtl; depends on nothing
package npm_pkg;

    localparam int DEF_MAX_POINTS = 1024;
    localparam int DEF_COORD_BITS = 24;

    localparam int DIST_BITS      = 52;
    localparam int INDEX_BITS     = 10;
    localparam int FUNC_BITS      = 2;
    localparam int CFG_ADDR_BITS  = 1;

    localparam logic [FUNC_BITS-1:0] FUNC_LOAD  = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_QUERY = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_CLEAR = 2'd2;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_MAX_DIST_SQ = 1'b0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_Z_OFFSET    = 1'b1;

    typedef struct packed {
        logic busy;
        logic result_push;
    } t_scan_status;

endpackage

>>> hw/rtl/nearest_point_height_mapper.sv
// nearest_point_height_mapper: top level with configuration registers and queues
// depends on npm_pkg, npm_fifo, npm_front and npm_scan
//
// usage:
// input channel: i_push / o_full, a transfer carries i_func and i_pos_x/y/z;
//   load appends a reference point (dropped when the store holds MAX_POINTS),
//   query asks for the mapped elevation, clear empties the store
// result channel: o_empty / i_pop, one result per query, in query order
// configuration: i_cfg_wr_en, i_cfg_addr, i_cfg_wdata; written while idle
// a query inside the bounding box is scanned against all N stored points, N being
//   the number of stored points, and a query outside it is not scanned;
//   the scan engine reads one stored point per cycle from the store
// the scan engine takes a new query only once the result of the last one is pushed
// a load or clear is held in the front register and retires once no query is pending
// the query queue holds up to two queries for the scan engine and the result queue two results;
//   a stalled receiver backs up into o_full, nothing is lost
// reset: empty store, zero bounding box, both registers zero, queues empty
module nearest_point_height_mapper #(
    parameter int MAX_POINTS = npm_pkg::DEF_MAX_POINTS,
    parameter int COORD_BITS = npm_pkg::DEF_COORD_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic [npm_pkg::FUNC_BITS-1:0]       i_func,
    input  logic signed [COORD_BITS-1:0]        i_pos_x,
    input  logic signed [COORD_BITS-1:0]        i_pos_y,
    input  logic signed [COORD_BITS-1:0]        i_pos_z,
    output logic                                o_empty,
    input  logic                                i_pop,
    output logic signed [COORD_BITS-1:0]        o_new_z,
    output logic                                o_matched,
    output logic [npm_pkg::INDEX_BITS-1:0]      o_match_index,
    output logic                                o_inside_box,
    input  logic                                i_cfg_wr_en,
    input  logic [npm_pkg::CFG_ADDR_BITS-1:0]   i_cfg_addr,
    input  logic [npm_pkg::DIST_BITS-1:0]       i_cfg_wdata
);

    localparam int CNTW = $clog2(MAX_POINTS + 1);
    localparam int IW   = $clog2(MAX_POINTS);
    localparam int QW   = 3 * COORD_BITS + CNTW + 1;
    localparam int RW   = COORD_BITS + npm_pkg::INDEX_BITS + 2;

    logic [npm_pkg::DIST_BITS-1:0] r_max_dist_sq;
    logic signed [COORD_BITS-1:0]  r_z_offset;

    npm_pkg::t_scan_status   scan_status;
    logic                    q_push;
    logic                    q_pop;
    logic                    q_empty;
    logic                    q_full;
    logic [QW-1:0]           q_wdata;
    logic [QW-1:0]           q_rdata;
    logic                    r_full;
    logic [RW-1:0]           r_wdata;
    logic [RW-1:0]           r_rdata;
    logic                    st_wr_en;
    logic [IW-1:0]           st_wr_addr;
    logic [3*COORD_BITS-1:0] st_wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dist_sq <= '0;
            r_z_offset    <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                npm_pkg::CFG_MAX_DIST_SQ: r_max_dist_sq <= i_cfg_wdata;
                npm_pkg::CFG_Z_OFFSET:    r_z_offset    <= i_cfg_wdata[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    npm_front #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_func        (i_func),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_scan_status (scan_status),
        .i_q_empty     (q_empty),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_data      (q_wdata),
        .o_wr_en       (st_wr_en),
        .o_wr_addr     (st_wr_addr),
        .o_wr_data     (st_wr_data)
    );

    npm_fifo #(
        .WIDTH (QW)
    ) u_query_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    npm_scan #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr_en       (st_wr_en),
        .i_wr_addr     (st_wr_addr),
        .i_wr_data     (st_wr_data),
        .i_q_empty     (q_empty),
        .i_q_data      (q_rdata),
        .o_q_pop       (q_pop),
        .i_r_full      (r_full),
        .o_r_data      (r_wdata),
        .i_max_dist_sq (r_max_dist_sq),
        .i_z_offset    (r_z_offset),
        .o_status      (scan_status)
    );

    npm_fifo #(
        .WIDTH (RW)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (scan_status.result_push),
        .i_data  (r_wdata),
        .i_pop   (i_pop),
        .o_data  (r_rdata),
        .o_empty (o_empty),
        .o_full  (r_full)
    );

    assign {o_new_z, o_matched, o_match_index, o_inside_box} = r_rdata;

`ifndef SYNTHESIS
    a_store_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_wr_en |-> (q_empty && !scan_status.busy))
        else $error("store written while a query is pending");

    a_result_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_status.result_push |-> !r_full)
        else $error("result pushed into a full queue");

    a_match_in_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_matched) |-> o_inside_box)
        else $error("match reported outside the bounding box");

    a_no_match_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_matched) |-> (o_match_index == '0))
        else $error("nonzero index without a match");
`endif

endmodule

>>> hw/rtl/npm_fifo.sv
// npm_fifo: two-entry queue used between the front, the scan engine and the result port
// depends on nothing
module npm_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= ~r_wptr;
            end
            if (do_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

>>> hw/rtl/npm_front.sv
// npm_front: takes items, keeps point count and bounding box, writes the store
// and forwards classified queries; depends on npm_pkg
module npm_front #(
    parameter int MAX_POINTS = npm_pkg::DEF_MAX_POINTS,
    parameter int COORD_BITS = npm_pkg::DEF_COORD_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    output logic                              o_full,
    input  logic [npm_pkg::FUNC_BITS-1:0]     i_func,
    input  logic signed [COORD_BITS-1:0]      i_pos_x,
    input  logic signed [COORD_BITS-1:0]      i_pos_y,
    input  logic signed [COORD_BITS-1:0]      i_pos_z,
    input  npm_pkg::t_scan_status             i_scan_status,
    input  logic                              i_q_empty,
    input  logic                              i_q_full,
    output logic                              o_q_push,
    output logic [3*COORD_BITS+$clog2(MAX_POINTS+1):0] o_q_data,
    output logic                              o_wr_en,
    output logic [$clog2(MAX_POINTS)-1:0]     o_wr_addr,
    output logic [3*COORD_BITS-1:0]           o_wr_data
);

    localparam int CNTW = $clog2(MAX_POINTS + 1);
    localparam int IW   = $clog2(MAX_POINTS);

    logic                          r_hold_v;
    logic [npm_pkg::FUNC_BITS-1:0] r_func;
    logic signed [COORD_BITS-1:0]  r_x;
    logic signed [COORD_BITS-1:0]  r_y;
    logic signed [COORD_BITS-1:0]  r_z;
    logic [CNTW-1:0]               r_count;
    logic signed [COORD_BITS-1:0]  r_min_x;
    logic signed [COORD_BITS-1:0]  r_max_x;
    logic signed [COORD_BITS-1:0]  r_min_y;
    logic signed [COORD_BITS-1:0]  r_max_y;

    logic is_query;
    logic back_idle;
    logic retire;
    logic accept;
    logic store_full;
    logic in_box;
    logic do_load;

    assign is_query   = (r_func == npm_pkg::FUNC_QUERY);
    assign back_idle  = i_q_empty && !i_scan_status.busy;
    assign retire     = r_hold_v && (is_query ? !i_q_full : back_idle);
    assign o_full     = r_hold_v && !retire;
    assign accept     = i_push && !o_full;
    assign store_full = (r_count == CNTW'(MAX_POINTS));
    assign do_load    = retire && (r_func == npm_pkg::FUNC_LOAD) && !store_full;

    assign in_box = (r_count != '0) && (r_x >= r_min_x) && (r_x <= r_max_x)
                    && (r_y >= r_min_y) && (r_y <= r_max_y);

    assign o_q_push  = retire && is_query;
    assign o_q_data  = {r_x, r_y, r_z, (in_box ? r_count : CNTW'(0)), in_box};
    assign o_wr_en   = do_load;
    assign o_wr_addr = r_count[IW-1:0];
    assign o_wr_data = {r_x, r_y, r_z};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
        end else if (accept) begin
            r_hold_v <= 1'b1;
        end else if (retire) begin
            r_hold_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_func;
            r_x    <= i_pos_x;
            r_y    <= i_pos_y;
            r_z    <= i_pos_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_min_x <= '0;
            r_max_x <= '0;
            r_min_y <= '0;
            r_max_y <= '0;
        end else if (do_load) begin
            r_count <= r_count + CNTW'(1);
            if (r_count == '0) begin
                r_min_x <= r_x;
                r_max_x <= r_x;
                r_min_y <= r_y;
                r_max_y <= r_y;
            end else begin
                if (r_x < r_min_x) r_min_x <= r_x;
                if (r_x > r_max_x) r_max_x <= r_x;
                if (r_y < r_min_y) r_min_y <= r_y;
                if (r_y > r_max_y) r_max_y <= r_y;
            end
        end else if (retire && (r_func == npm_pkg::FUNC_CLEAR)) begin
            r_count <= '0;
            r_min_x <= '0;
            r_max_x <= '0;
            r_min_y <= '0;
            r_max_y <= '0;
        end
    end

endmodule

>>> hw/rtl/npm_scan.sv
// npm_scan: point store and the distance scan engine, one stored point per cycle
// depends on npm_pkg
module npm_scan #(
    parameter int MAX_POINTS = npm_pkg::DEF_MAX_POINTS,
    parameter int COORD_BITS = npm_pkg::DEF_COORD_BITS
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_wr_en,
    input  logic [$clog2(MAX_POINTS)-1:0]             i_wr_addr,
    input  logic [3*COORD_BITS-1:0]                   i_wr_data,
    input  logic                                      i_q_empty,
    input  logic [3*COORD_BITS+$clog2(MAX_POINTS+1):0] i_q_data,
    output logic                                      o_q_pop,
    input  logic                                      i_r_full,
    output logic [COORD_BITS+npm_pkg::INDEX_BITS+1:0] o_r_data,
    input  logic [npm_pkg::DIST_BITS-1:0]             i_max_dist_sq,
    input  logic signed [COORD_BITS-1:0]              i_z_offset,
    output npm_pkg::t_scan_status                     o_status
);

    localparam int CNTW = $clog2(MAX_POINTS + 1);
    localparam int IW   = $clog2(MAX_POINTS);
    localparam int MW   = COORD_BITS + 1;
    localparam int SW   = 2 * MW;
    localparam int DW   = SW + 1;
    localparam int CMPW = (DW > npm_pkg::DIST_BITS) ? DW : npm_pkg::DIST_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [3*COORD_BITS-1:0] mem [MAX_POINTS];

    logic [1:0]                   r_state;
    logic [1:0]                   n_state;
    logic signed [COORD_BITS-1:0] r_qx;
    logic signed [COORD_BITS-1:0] r_qy;
    logic signed [COORD_BITS-1:0] r_qz;
    logic [CNTW-1:0]              r_limit;
    logic                         r_inside;
    logic [CNTW-1:0]              r_addr;

    logic                         r_v1;
    logic [IW-1:0]                r_idx1;
    logic [3*COORD_BITS-1:0]      r_rd;
    logic                         r_v2;
    logic [IW-1:0]                r_idx2;
    logic [COORD_BITS-1:0]        r_z2;
    logic [MW-1:0]                r_adx;
    logic [MW-1:0]                r_ady;
    logic                         r_v3;
    logic [IW-1:0]                r_idx3;
    logic [COORD_BITS-1:0]        r_z3;
    logic [SW-1:0]                r_sx;
    logic [SW-1:0]                r_sy;
    logic                         r_v4;
    logic [IW-1:0]                r_idx4;
    logic [COORD_BITS-1:0]        r_z4;
    logic [DW-1:0]                r_d;

    logic                         r_found;
    logic [DW-1:0]                r_best;
    logic [IW-1:0]                r_best_idx;
    logic signed [COORD_BITS-1:0] r_best_z;

    logic                         start;
    logic                         issue;
    logic                         drained;
    logic                         better;
    logic signed [COORD_BITS-1:0] rd_x;
    logic signed [COORD_BITS-1:0] rd_y;
    logic signed [MW-1:0]         dx;
    logic signed [MW-1:0]         dy;
    logic signed [MW-1:0]         zdiff;
    logic signed [COORD_BITS-1:0] zsat;
    logic signed [COORD_BITS-1:0] new_z;

    assign start   = (r_state == S_IDLE) && !i_q_empty && !i_r_full;
    assign issue   = (r_state == S_RUN) && (r_addr != r_limit);
    assign drained = (r_state == S_RUN) && (r_addr == r_limit)
                     && !r_v1 && !r_v2 && !r_v3 && !r_v4;
    assign o_q_pop = start;

    assign o_status.busy        = (r_state != S_IDLE);
    assign o_status.result_push = (r_state == S_DONE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (start) n_state = S_RUN;
            S_RUN:   if (drained) n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_addr  <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= issue;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            if (start) begin
                r_addr  <= '0;
                r_found <= 1'b0;
            end else begin
                if (issue) begin
                    r_addr <= r_addr + CNTW'(1);
                end
                if (r_v4 && better) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (issue) begin
            r_rd <= mem[r_addr[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            {r_qx, r_qy, r_qz, r_limit, r_inside} <= i_q_data;
        end
    end

    // distance pipeline: difference, square, sum, compare
    assign rd_x  = r_rd[3*COORD_BITS-1:2*COORD_BITS];
    assign rd_y  = r_rd[2*COORD_BITS-1:COORD_BITS];
    assign dx    = MW'(r_qx) - MW'(rd_x);
    assign dy    = MW'(r_qy) - MW'(rd_y);
    assign better = (CMPW'(r_d) < CMPW'(i_max_dist_sq)) && (!r_found || (r_d < r_best));

    always_ff @(posedge i_clk) begin
        r_idx1 <= r_addr[IW-1:0];
        r_idx2 <= r_idx1;
        r_z2   <= r_rd[COORD_BITS-1:0];
        r_adx  <= dx[MW-1] ? MW'(-dx) : MW'(dx);
        r_ady  <= dy[MW-1] ? MW'(-dy) : MW'(dy);
        r_idx3 <= r_idx2;
        r_z3   <= r_z2;
        r_sx   <= SW'(r_adx) * SW'(r_adx);
        r_sy   <= SW'(r_ady) * SW'(r_ady);
        r_idx4 <= r_idx3;
        r_z4   <= r_z3;
        r_d    <= DW'(r_sx) + DW'(r_sy);
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_best_idx <= '0;
        end else if (r_v4 && better) begin
            r_best     <= r_d;
            r_best_idx <= r_idx4;
            r_best_z   <= r_z4;
        end
    end

    // saturated z minus offset
    assign zdiff = MW'(r_best_z) - MW'(i_z_offset);
    always_comb begin
        if (zdiff[MW-1] != zdiff[MW-2]) begin
            zsat = zdiff[MW-1] ? {1'b1, {(COORD_BITS-1){1'b0}}}
                               : {1'b0, {(COORD_BITS-1){1'b1}}};
        end else begin
            zsat = zdiff[COORD_BITS-1:0];
        end
    end
    assign new_z = r_found ? zsat : r_qz;

    assign o_r_data = {new_z, r_found,
                       (r_found ? npm_pkg::INDEX_BITS'(r_best_idx) : npm_pkg::INDEX_BITS'(0)),
                       r_inside};

endmodule

>>> tb/nearest_point_height_mapper_tb.sv
// nearest_point_height_mapper_tb: self-checking testbench for the nearest point height mapper
// drives loads, queries and clears through the queue ports and checks every mapped elevation
// depends on npm_pkg and nearest_point_height_mapper under hw/rtl
module nearest_point_height_mapper_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = npm_pkg::DEF_COORD_BITS;
    localparam int MAXP = npm_pkg::DEF_MAX_POINTS;
    localparam int DW = npm_pkg::DIST_BITS;
    localparam int IW = npm_pkg::INDEX_BITS;
    localparam int AW = npm_pkg::CFG_ADDR_BITS;
    localparam logic [npm_pkg::FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;
    localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [DW-1:0] RADIUS_MAX = {DW{1'b1}};
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic signed [CW-1:0] new_z;
        logic                 matched;
        logic [IW-1:0]        index;
        logic                 in_box;
    } t_height_result;

    class t_height_scoreboard;
        logic signed [CW-1:0] ref_x [MAXP];
        logic signed [CW-1:0] ref_y [MAXP];
        logic signed [CW-1:0] ref_z [MAXP];
        logic signed [CW-1:0] min_x, max_x, min_y, max_y;
        logic [DW-1:0]        radius_sq;
        logic signed [CW-1:0] z_shift;
        t_height_result       expected_heights [$];
        int n_points, n_loads, n_dropped, n_clears, n_queries, n_matched, n_clamped;
        int mismatches;

        function new();
            n_points = 0;
            min_x = '0;
            max_x = '0;
            min_y = '0;
            max_y = '0;
            radius_sq = '0;
            z_shift = '0;
            n_loads = 0;
            n_dropped = 0;
            n_clears = 0;
            n_queries = 0;
            n_matched = 0;
            n_clamped = 0;
            mismatches = 0;
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= REPORT_LIMIT) $display("%0t ns: %s", $time, msg);
        endfunction

        function void write_register(logic [AW-1:0] addr, logic [DW-1:0] data);
            if (addr == npm_pkg::CFG_MAX_DIST_SQ) radius_sq = data;
            else z_shift = data[CW-1:0];
        endfunction

        function void note_transfer(logic [npm_pkg::FUNC_BITS-1:0] func,
                                    logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                    logic signed [CW-1:0] z);
            t_height_result res;
            longint dx, dy, nz;
            longint unsigned sq_dist, best;
            best = 0;
            if (func == npm_pkg::FUNC_LOAD) begin
                if (n_points >= MAXP) begin
                    n_dropped++;
                    return;
                end
                if (n_points == 0) begin
                    min_x = x;
                    max_x = x;
                    min_y = y;
                    max_y = y;
                end else begin
                    if (x < min_x) min_x = x;
                    if (x > max_x) max_x = x;
                    if (y < min_y) min_y = y;
                    if (y > max_y) max_y = y;
                end
                ref_x[n_points] = x;
                ref_y[n_points] = y;
                ref_z[n_points] = z;
                n_points++;
                n_loads++;
            end else if (func == npm_pkg::FUNC_CLEAR) begin
                n_points = 0;
                min_x = '0;
                max_x = '0;
                min_y = '0;
                max_y = '0;
                n_clears++;
            end else if (func == npm_pkg::FUNC_QUERY) begin
                n_queries++;
                res.in_box = n_points != 0 && x >= min_x && x <= max_x &&
                             y >= min_y && y <= max_y;
                res.matched = 1'b0;
                res.index = '0;
                res.new_z = z;
                if (res.in_box) begin
                    for (int i = 0; i < n_points; i++) begin
                        dx = longint'(x) - longint'(ref_x[i]);
                        dy = longint'(y) - longint'(ref_y[i]);
                        sq_dist = dx * dx + dy * dy;
                        if (sq_dist < radius_sq && (!res.matched || sq_dist < best)) begin
                            res.matched = 1'b1;
                            best = sq_dist;
                            res.index = IW'(i);
                        end
                    end
                end
                if (res.matched) begin
                    nz = longint'(ref_z[res.index]) - longint'(z_shift);
                    if (nz > longint'(COORD_MAX)) begin
                        nz = longint'(COORD_MAX);
                        n_clamped++;
                    end
                    if (nz < longint'(COORD_MIN)) begin
                        nz = longint'(COORD_MIN);
                        n_clamped++;
                    end
                    res.new_z = nz[CW-1:0];
                    n_matched++;
                end
                expected_heights = {expected_heights, res};
            end
        endfunction

        function void check_result(logic signed [CW-1:0] new_z, logic matched,
                                   logic [IW-1:0] index, logic in_box);
            t_height_result res;
            if (expected_heights.size() == 0) begin
                report($sformatf({"result with no query waiting:",
                                  " new_z %0d matched %0b index %0d inside %0b"},
                                 new_z, matched, index, in_box));
                return;
            end
            res = expected_heights.pop_front();
            if (new_z !== res.new_z || matched !== res.matched ||
                index !== res.index || in_box !== res.in_box)
                report($sformatf({"mapping mismatch: expected new_z %0d matched %0b",
                                  " index %0d inside %0b,",
                                  " got new_z %0d matched %0b index %0d inside %0b"},
                                 res.new_z, res.matched, res.index, res.in_box,
                                 new_z, matched, index, in_box));
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_push;
    logic                          o_full;
    logic [npm_pkg::FUNC_BITS-1:0] i_func;
    logic signed [CW-1:0]          i_pos_x;
    logic signed [CW-1:0]          i_pos_y;
    logic signed [CW-1:0]          i_pos_z;
    logic                          o_empty;
    logic                          i_pop = 1'b0;
    logic signed [CW-1:0]          o_new_z;
    logic                          o_matched;
    logic [IW-1:0]                 o_match_index;
    logic                          o_inside_box;
    logic                          i_cfg_wr_en;
    logic [AW-1:0]                 i_cfg_addr;
    logic [DW-1:0]                 i_cfg_wdata;

    t_height_scoreboard heights;
    int sender_idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    nearest_point_height_mapper dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(negedge i_clk) i_pop = ($urandom_range(99) >= stall_pct);

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_pop && !o_empty)
                heights.check_result(o_new_z, o_matched, o_match_index, o_inside_box);
            if ((i_push && !o_full) || (i_pop && !o_empty)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer in %0d cycles", WATCHDOG_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic logic signed [CW-1:0] any_coord();
        logic [31:0] r;
        r = $urandom();
        return r[CW-1:0];
    endfunction

    function automatic logic signed [CW-1:0] scatter(int center, int spread);
        int v;
        v = center - spread + int'($urandom_range(2 * spread));
        return v[CW-1:0];
    endfunction

    task automatic send_item(input logic [npm_pkg::FUNC_BITS-1:0] func,
                             input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                             input logic signed [CW-1:0] z);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_push = 1'b0;
            @(negedge i_clk);
        end
        i_push = 1'b1;
        i_func = func;
        i_pos_x = x;
        i_pos_y = y;
        i_pos_z = z;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        heights.note_transfer(func, x, y, z);
        @(negedge i_clk);
        i_push = 1'b0;
    endtask

    task automatic wait_drain();
        while (heights.expected_heights.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // loads and clears give no result, so let them retire before touching registers
    task automatic settle();
        wait_drain();
        repeat (16) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [AW-1:0] addr, input logic [DW-1:0] data);
        i_cfg_wr_en = 1'b1;
        i_cfg_addr = addr;
        i_cfg_wdata = data;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        heights.write_register(addr, data);
    endtask

    task automatic configure(input logic [DW-1:0] radius, input logic signed [CW-1:0] offset);
        write_register(npm_pkg::CFG_MAX_DIST_SQ, radius);
        write_register(npm_pkg::CFG_Z_OFFSET, {{(DW-CW){offset[CW-1]}}, offset});
    endtask

    task automatic set_pacing(input int mode);
        sender_idle_pct = 0;
        stall_pct = 0;
        if (mode == 1) sender_idle_pct = 65;
        if (mode == 2) stall_pct = 65;
        if (mode == 3) begin
            sender_idle_pct = 18;
            stall_pct = 18;
        end
    endtask

    // mostly clustered loads and queries so that scans find real matches
    task automatic run_phase(input int items, input int spread, input bit pause_midway);
        int done, cap, pick, cx, cy, lim;
        lim = (1 << (CW - 1)) - 1 - spread;
        cx = int'($urandom_range(2 * lim)) - lim;
        cy = int'($urandom_range(2 * lim)) - lim;
        cap = $urandom_range(4, 40);
        done = 0;
        while (done < items) begin
            if (pause_midway && done == items / 2) begin
                wait_drain();
                pause_midway = 1'b0;
            end
            pick = $urandom_range(99);
            if (heights.n_points > cap) begin
                send_item(npm_pkg::FUNC_CLEAR, any_coord(), any_coord(), any_coord());
                cap = $urandom_range(4, 40);
            end else if (pick < 42) begin
                send_item(npm_pkg::FUNC_LOAD, scatter(cx, spread), scatter(cy, spread),
                          any_coord());
            end else if (pick < 82) begin
                send_item(npm_pkg::FUNC_QUERY, scatter(cx, spread), scatter(cy, spread),
                          any_coord());
            end else if (pick < 88) begin
                send_item(npm_pkg::FUNC_QUERY, any_coord(), any_coord(), any_coord());
            end else if (pick < 92) begin
                send_item(npm_pkg::FUNC_LOAD, any_coord(), any_coord(), any_coord());
            end else if (pick < 96) begin
                send_item(npm_pkg::FUNC_CLEAR, any_coord(), any_coord(), any_coord());
            end else begin
                send_item(FUNC_UNUSED, any_coord(), any_coord(), any_coord());
                continue;
            end
            done++;
        end
    endtask

    initial begin
        logic [DW-1:0]        radii   [6];
        logic signed [CW-1:0] offsets [6];
        int                   spreads [6];

        heights = new();
        i_rst_n = 1'b0;
        i_push = 1'b0;
        i_func = npm_pkg::FUNC_LOAD;
        i_pos_x = '0;
        i_pos_y = '0;
        i_pos_z = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_addr = npm_pkg::CFG_MAX_DIST_SQ;
        i_cfg_wdata = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (4) @(negedge i_clk);

        // directed corners
        configure(1024, 0);
        set_pacing(3);
        send_item(npm_pkg::FUNC_QUERY, 100, -100, 77);
        send_item(npm_pkg::FUNC_LOAD, 0, 0, 100);
        send_item(npm_pkg::FUNC_QUERY, 0, 0, 5);
        send_item(npm_pkg::FUNC_LOAD, 10, 0, 200);
        send_item(npm_pkg::FUNC_QUERY, 5, 0, 1);
        send_item(npm_pkg::FUNC_QUERY, 0, 3, -4);
        send_item(npm_pkg::FUNC_LOAD, 2000, 2000, -300);
        send_item(npm_pkg::FUNC_QUERY, 1000, 1000, 9);
        send_item(npm_pkg::FUNC_QUERY, 1968, 2000, 11);
        send_item(npm_pkg::FUNC_QUERY, 1969, 2000, 12);
        send_item(npm_pkg::FUNC_LOAD, COORD_MAX, COORD_MAX, COORD_MAX);
        send_item(npm_pkg::FUNC_LOAD, COORD_MIN, COORD_MIN, COORD_MIN);
        send_item(npm_pkg::FUNC_QUERY, COORD_MAX, COORD_MAX, 0);
        send_item(npm_pkg::FUNC_QUERY, COORD_MIN, COORD_MIN, 0);
        send_item(FUNC_UNUSED, any_coord(), any_coord(), any_coord());
        send_item(npm_pkg::FUNC_CLEAR, 0, 0, 0);
        send_item(npm_pkg::FUNC_QUERY, 0, 0, 42);
        send_item(npm_pkg::FUNC_LOAD, -7, 9, 55);
        send_item(npm_pkg::FUNC_QUERY, -7, 9, 3);
        send_item(npm_pkg::FUNC_QUERY, -6, 9, 3);

        // a larger store for long scans, the last load wins the top index
        settle();
        configure(RADIUS_MAX, COORD_MIN);
        set_pacing(0);
        send_item(npm_pkg::FUNC_CLEAR, 0, 0, 0);
        for (int i = 0; i < 199; i++)
            send_item(npm_pkg::FUNC_LOAD, scatter(0, 4096), scatter(0, 4096), any_coord());
        send_item(npm_pkg::FUNC_LOAD, 5000, -5000, 1234567);
        send_item(npm_pkg::FUNC_QUERY, 5000, -5000, 0);
        send_item(npm_pkg::FUNC_LOAD, 8000000, 8000000, 1);
        send_item(npm_pkg::FUNC_LOAD, -8000000, -8000000, 2);
        send_item(npm_pkg::FUNC_QUERY, 8000000, 8000000, 77);
        send_item(npm_pkg::FUNC_QUERY, scatter(0, 4096), scatter(0, 4096), any_coord());
        send_item(npm_pkg::FUNC_QUERY, 0, 0, any_coord());

        radii[0] = '0;
        radii[1] = 2000;
        radii[2] = RADIUS_MAX;
        radii[3] = 50000;
        radii[4] = DW'({$urandom(), $urandom()});
        radii[5] = 400;
        offsets[0] = '0;
        offsets[1] = any_coord();
        offsets[2] = COORD_MIN;
        offsets[3] = COORD_MAX;
        offsets[4] = any_coord();
        offsets[5] = any_coord();
        spreads[0] = 64;
        spreads[1] = 64;
        spreads[2] = 1000;
        spreads[3] = 300;
        spreads[4] = 1 << 20;
        spreads[5] = 32;
        for (int p = 0; p < 6; p++) begin
            settle();
            configure(radii[p], offsets[p]);
            set_pacing(p % 4);
            run_phase(56, spreads[p], p == 3);
        end

        settle();
        repeat (40) @(negedge i_clk);
        $display("covered %0d loads (%0d dropped on a full store), %0d clears, %0d queries",
                 heights.n_loads, heights.n_dropped, heights.n_clears, heights.n_queries);
        $display("%0d queries matched, %0d elevations saturated, %0d mismatches",
                 heights.n_matched, heights.n_clamped, heights.mismatches);
        if (heights.mismatches == 0 && heights.expected_heights.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            if (heights.expected_heights.size() != 0)
                $display("%0d query results never arrived", heights.expected_heights.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
